// ===== hw/rtl/bct_pkg.sv =====
// Shared types and constants for the bone chain transform block.
package bct_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = 6;
  localparam int Q_ROT = 28;
  localparam int ROT_W = 34;
  localparam int ROT_E_W = 36;
  localparam int PROD_W = 66;
  localparam int ACC_W = 68;

  typedef logic signed [31:0] word_t;
  typedef logic signed [15:0] quat_el_t;
  typedef logic signed [6:0] parent_t;

  typedef struct packed {
    parent_t  parent;
    word_t    tx;
    word_t    ty;
    word_t    tz;
    quat_el_t qw;
    quat_el_t qx;
    quat_el_t qy;
    quat_el_t qz;
  } entry_t;

  typedef logic signed [ROT_W-1:0] rel_t;
  typedef rel_t [8:0] rot_t;
  typedef word_t [11:0] mat_t;
  typedef word_t [2:0] vec_t;

  typedef struct packed {
    logic init;
    logic start;
  } aff_ctl_t;
endpackage

// ===== hw/rtl/bct_if.sv =====
// Handshake channel interfaces for query and write items and for result rows.
interface bct_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  bone;
  logic signed [6:0]  parent;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, func, bone, parent, trans_x, trans_y, trans_z,
                 quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, func, bone, parent, trans_x, trans_y, trans_z,
               quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface bct_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic        last;
  logic        chain_error;
  modport source(output valid, row, col0, col1, col2, col3, last, chain_error,
                 input ready);
  modport sink(input valid, row, col0, col1, col2, col3, last, chain_error,
               output ready);
endinterface

// ===== hw/rtl/bone_chain_transform_unit.sv =====
// Top level: bone table, chain walk sequencer and result row output.
// A write item is written to the table on its handshake. A query walks L levels
// of the parent chain, each level a table read, a rotation matrix on one
// multiplier, an affine product on one 34x32 multiplier and a parent check,
// then three result rows follow, one per accepted handshake; one item at a time.
// Synchronous reset clears the control state; the bone table is not cleared.
module bone_chain_transform_unit #(
  parameter int BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  bct_req_if.sink   req,
  bct_rsp_if.source rsp
);
  import bct_pkg::*;

  localparam int LVL_W = (BONES > 1) ? $clog2(BONES) : 1;

  typedef enum logic [5:0] {
    IDLE = 6'b000001,
    READ = 6'b000010,
    ROT  = 6'b000100,
    AFF  = 6'b001000,
    WAIT = 6'b010000,
    OUT  = 6'b100000
  } state_t;

  state_t state;
  entry_t wdata, rdata;
  logic [IDX_W-1:0] raddr, tbl_raddr;
  logic [LVL_W-1:0] lvl;
  logic [1:0] row;
  logic chain_error;
  logic we, rot_start, rot_done, aff_done;
  aff_ctl_t aff_ctl;
  rot_t r;
  mat_t m;
  vec_t t;
  parent_t parent;

  assign req.ready = (state == IDLE);
  assign we = req.valid && req.ready && !req.func;
  assign wdata = '{parent: req.parent, tx: req.trans_x, ty: req.trans_y,
                   tz: req.trans_z, qw: req.quat_w, qx: req.quat_x,
                   qy: req.quat_y, qz: req.quat_z};
  assign rot_start = (state == READ);
  assign aff_ctl.init = req.valid && req.ready && req.func;
  assign aff_ctl.start = (state == ROT) && rot_done;
  assign tbl_raddr = (state == IDLE) ? req.bone :
                     (state == WAIT) ? parent[IDX_W-1:0] : raddr;

  bct_table u_table (
    .clk(clk), .we(we), .waddr(req.bone), .wdata(wdata),
    .raddr(tbl_raddr), .rdata(rdata)
  );

  bct_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk(clk), .rst(rst), .start(rot_start),
    .qw(rdata.qw), .qx(rdata.qx), .qy(rdata.qy), .qz(rdata.qz),
    .r(r), .done(rot_done)
  );

  bct_affine #(.FRAC_BITS(FRAC_BITS)) u_affine (
    .clk(clk), .rst(rst), .ctl(aff_ctl), .r(r), .t(t), .m(m), .done(aff_done)
  );

  always_ff @(posedge clk) begin
    if (state == READ) begin
      t[0] <= rdata.tx;
      t[1] <= rdata.ty;
      t[2] <= rdata.tz;
      parent <= rdata.parent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      raddr <= '0;
      lvl <= '0;
      row <= 2'd0;
      chain_error <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req.valid && req.func) begin
            raddr <= req.bone;
            lvl <= '0;
            state <= READ;
          end
        end
        READ: begin
          state <= ROT;
        end
        ROT: begin
          if (rot_done) begin
            state <= AFF;
          end
        end
        AFF: begin
          if (aff_done) begin
            state <= WAIT;
          end
        end
        WAIT: begin
          if (parent[6]) begin
            chain_error <= 1'b0;
            row <= 2'd0;
            state <= OUT;
          end else if (lvl == LVL_W'(BONES - 1)) begin
            chain_error <= 1'b1;
            row <= 2'd0;
            state <= OUT;
          end else begin
            lvl <= lvl + LVL_W'(1);
            raddr <= parent[IDX_W-1:0];
            state <= READ;
          end
        end
        OUT: begin
          if (rsp.ready) begin
            if (row == 2'd2) begin
              state <= IDLE;
            end
            row <= row + 2'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.valid = (state == OUT);
  assign rsp.row = row;
  assign rsp.col0 = m[{row, 2'd0}];
  assign rsp.col1 = m[{row, 2'd1}];
  assign rsp.col2 = m[{row, 2'd2}];
  assign rsp.col3 = m[{row, 2'd3}];
  assign rsp.last = (row == 2'd2);
  assign rsp.chain_error = chain_error;
endmodule

// ===== hw/rtl/bct_table.sv =====
// Bone table memory with one write port and one registered read port.
module bct_table (
  input  logic                     clk,
  input  logic                     we,
  input  logic [bct_pkg::IDX_W-1:0] waddr,
  input  bct_pkg::entry_t          wdata,
  input  logic [bct_pkg::IDX_W-1:0] raddr,
  output bct_pkg::entry_t          rdata
);
  import bct_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/bct_rot.sv =====
// Quaternion to rotation matrix unit on one shared 16x16 multiplier.
module bct_rot #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bct_pkg::quat_el_t qw,
  input  bct_pkg::quat_el_t qx,
  input  bct_pkg::quat_el_t qy,
  input  bct_pkg::quat_el_t qz,
  output bct_pkg::rot_t     r,
  output logic              done
);
  import bct_pkg::*;

  localparam int SH = Q_ROT - FRAC_BITS;
  localparam logic signed [ROT_E_W-1:0] ONE = ROT_E_W'(1) <<< Q_ROT;
  localparam logic signed [ROT_E_W-1:0] HALF = ROT_E_W'(1) <<< (SH - 1);

  quat_el_t w, x, y, z, a, b;
  logic signed [31:0] prod [9];
  logic [3:0] cnt;
  logic busy;
  logic signed [ROT_E_W-1:0] p [9];
  logic signed [ROT_E_W-1:0] e [9];

  always_comb begin
    case (cnt)
      4'd0: begin a = x; b = x; end
      4'd1: begin a = y; b = y; end
      4'd2: begin a = z; b = z; end
      4'd3: begin a = x; b = y; end
      4'd4: begin a = w; b = z; end
      4'd5: begin a = x; b = z; end
      4'd6: begin a = w; b = y; end
      4'd7: begin a = y; b = z; end
      default: begin a = w; b = x; end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p[k] = ROT_E_W'(prod[k]);
    end
    e[0] = ONE - ((p[1] + p[2]) <<< 1);
    e[1] = (p[3] - p[4]) <<< 1;
    e[2] = (p[5] + p[6]) <<< 1;
    e[3] = (p[3] + p[4]) <<< 1;
    e[4] = ONE - ((p[0] + p[2]) <<< 1);
    e[5] = (p[7] - p[8]) <<< 1;
    e[6] = (p[5] - p[6]) <<< 1;
    e[7] = (p[7] + p[8]) <<< 1;
    e[8] = ONE - ((p[0] + p[1]) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 4'd0;
      end else if (busy) begin
        if (cnt == 4'd9) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w <= qw;
      x <= qx;
      y <= qy;
      z <= qz;
    end
    if (busy && cnt < 4'd9) begin
      prod[cnt] <= a * b;
    end
    if (busy && cnt == 4'd9) begin
      for (int k = 0; k < 9; k++) begin
        r[k] <= ROT_W'((e[k] + HALF) >>> SH);
      end
    end
  end
endmodule

// ===== hw/rtl/bct_affine.sv =====
// Accumulated affine matrix and the sequential 3x4 product of one chain level.
module bct_affine #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bct_pkg::aff_ctl_t ctl,
  input  bct_pkg::rot_t     r,
  input  bct_pkg::vec_t     t,
  output bct_pkg::mat_t     m,
  output logic              done
);
  import bct_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32'sh7fffffff);
  localparam logic signed [ACC_W-1:0] SMIN = -ACC_W'(64'sh80000000);
  localparam word_t UNIT = 32'(1) <<< FRAC_BITS;

  mat_t n;
  logic [1:0] i, j, k;
  logic [2:0] s;
  logic busy, fin;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, rnd;
  word_t m_sel, sat;
  rel_t r_sel;
  logic [3:0] m_idx, r_idx, n_idx;

  assign k = s[1:0];
  assign m_idx = {k, j};
  assign r_idx = {1'b0, i, 1'b0} + {2'b00, i} + {2'b00, k};
  assign n_idx = {i, j};
  assign m_sel = (m_idx < 4'd12) ? m[m_idx] : '0;
  assign r_sel = (r_idx < 4'd9) ? r[r_idx] : '0;
  assign rnd = (acc + HALF) >>> FRAC_BITS;

  always_comb begin
    if (rnd > SMAX) begin
      sat = 32'sh7fffffff;
    end else if (rnd < SMIN) begin
      sat = 32'sh80000000;
    end else begin
      sat = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
      i <= 2'd0;
      j <= 2'd0;
      s <= 3'd0;
    end else begin
      done <= 1'b0;
      fin <= 1'b0;
      if (fin) begin
        done <= 1'b1;
      end
      if (ctl.start) begin
        busy <= 1'b1;
        i <= 2'd0;
        j <= 2'd0;
        s <= 3'd0;
      end else if (busy) begin
        if (s == 3'd4) begin
          s <= 3'd0;
          if (j == 2'd3) begin
            j <= 2'd0;
            if (i == 2'd2) begin
              busy <= 1'b0;
              fin <= 1'b1;
            end else begin
              i <= i + 2'd1;
            end
          end else begin
            j <= j + 2'd1;
          end
        end else begin
          s <= s + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= r_sel * m_sel;
    if (busy) begin
      case (s)
        3'd0: begin
          acc <= (j == 2'd3) ? (ACC_W'(t[i]) <<< FRAC_BITS) : '0;
        end
        3'd4: begin
          n[n_idx] <= sat;
        end
        default: begin
          acc <= acc + ACC_W'(prod);
        end
      endcase
    end
    if (ctl.init) begin
      for (int q = 0; q < 12; q++) begin
        m[q] <= (q == 0 || q == 5 || q == 10) ? UNIT : '0;
      end
    end else if (fin) begin
      m <= n;
    end
  end
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the bone chain transform unit: directed table, random chains.
module tb;
  import bct_pkg::*;

  typedef struct {
    logic     func;
    logic [5:0] bone;
    parent_t  parent;
    word_t    tx, ty, tz;
    quat_el_t qw, qx, qy, qz;
  } item_t;

  typedef struct {
    logic [1:0] row;
    word_t      c0, c1, c2, c3;
    logic       last;
    logic       err;
  } row_t;

  typedef struct {
    item_t it;
    bit    typed;
    word_t t0, t1, t2;
    bit    err;
  } dir_t;

  localparam int FUNC_WRITE = 0;
  localparam int FUNC_QUERY = 1;
  localparam int CHAIN_LIMIT = 64;
  localparam int FRAC = 16;
  localparam int WATCHDOG = 40000;

  logic clk = 0;
  logic rst = 1;
  bct_req_if req();
  bct_rsp_if rsp();

  bone_chain_transform_unit uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  parent_t  tbl_parent [TABLE_DEPTH];
  word_t    tbl_t [TABLE_DEPTH][3];
  quat_el_t tbl_q [TABLE_DEPTH][4];

  bit       gen_written [TABLE_DEPTH];
  parent_t  gen_parent [TABLE_DEPTH];

  row_t     rows_due [$];
  bit       typed_flags [$];
  row_t     typed_rows [$];
  int       errors = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;
  int       quiet = 0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void chain_transform(input logic [5:0] start, output row_t res [3]);
    longint m [3][4];
    longint n [3][4];
    longint r [3][3];
    longint e [3][3];
    longint w, x, y, z, acc, one;
    logic [5:0] idx;
    bit done;
    one = longint'(1) << Q_ROT;
    idx = start;
    done = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++)
        m[i][j] = (i == j) ? (longint'(1) << FRAC) : 0;
    for (int lvl = 0; lvl < CHAIN_LIMIT && !done; lvl++) begin
      w = tbl_q[idx][0];
      x = tbl_q[idx][1];
      y = tbl_q[idx][2];
      z = tbl_q[idx][3];
      e[0][0] = one - 2 * (y * y + z * z);
      e[0][1] = 2 * (x * y - w * z);
      e[0][2] = 2 * (x * z + w * y);
      e[1][0] = 2 * (x * y + w * z);
      e[1][1] = one - 2 * (x * x + z * z);
      e[1][2] = 2 * (y * z - w * x);
      e[2][0] = 2 * (x * z - w * y);
      e[2][1] = 2 * (y * z + w * x);
      e[2][2] = one - 2 * (x * x + y * y);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          r[i][j] = rnd_shift(e[i][j], Q_ROT - FRAC);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += r[i][k] * m[k][j];
          if (j == 3)
            acc += longint'(tbl_t[idx][i]) * (longint'(1) << FRAC);
          n[i][j] = sat(rnd_shift(acc, FRAC));
        end
      m = n;
      if (tbl_parent[idx] < 0)
        done = 1;
      else
        idx = tbl_parent[idx][5:0];
    end
    for (int i = 0; i < 3; i++) begin
      res[i].row = 2'(i);
      res[i].c0 = 32'(m[i][0]);
      res[i].c1 = 32'(m[i][1]);
      res[i].c2 = 32'(m[i][2]);
      res[i].c3 = 32'(m[i][3]);
      res[i].last = (i == 2);
      res[i].err = !done;
    end
  endfunction

  always @(posedge clk) begin
    row_t res [3];
    if (!rst && req.valid && req.ready) begin
      if (req.func == FUNC_WRITE) begin
        tbl_parent[req.bone] <= req.parent;
        tbl_t[req.bone][0] <= req.trans_x;
        tbl_t[req.bone][1] <= req.trans_y;
        tbl_t[req.bone][2] <= req.trans_z;
        tbl_q[req.bone][0] <= req.quat_w;
        tbl_q[req.bone][1] <= req.quat_x;
        tbl_q[req.bone][2] <= req.quat_y;
        tbl_q[req.bone][3] <= req.quat_z;
      end else if (typed_flags.pop_front()) begin
        for (int i = 0; i < 3; i++) rows_due = {rows_due, typed_rows.pop_front()};
      end else begin
        chain_transform(req.bone, res);
        for (int i = 0; i < 3; i++) rows_due = {rows_due, res[i]};
      end
    end
  end

  always @(posedge clk) begin
    row_t exp_row;
    if (!rst && rsp.valid && rsp.ready) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row %0d, nothing expected", $time, rsp.row);
        errors++;
      end else begin
        exp_row = rows_due.pop_front();
        if (rsp.row !== exp_row.row || rsp.col0 !== exp_row.c0 || rsp.col1 !== exp_row.c1 ||
            rsp.col2 !== exp_row.c2 || rsp.col3 !== exp_row.c3 ||
            rsp.last !== exp_row.last || rsp.chain_error !== exp_row.err) begin
          $display("%0t: expected row %0d %h %h %h %h last %b err %b", $time, exp_row.row,
                   exp_row.c0, exp_row.c1, exp_row.c2, exp_row.c3, exp_row.last, exp_row.err);
          $display("%0t: actual   row %0d %h %h %h %h last %b err %b", $time, rsp.row,
                   rsp.col0, rsp.col1, rsp.col2, rsp.col3, rsp.last, rsp.chain_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("[bone_chain_transform_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic bit chain_ready(logic [5:0] start);
    logic [5:0] idx;
    idx = start;
    for (int lvl = 0; lvl < CHAIN_LIMIT; lvl++) begin
      if (!gen_written[idx]) return 0;
      if (gen_parent[idx] < 0) return 1;
      idx = gen_parent[idx][5:0];
    end
    return 1;
  endfunction

  task automatic send(input item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    if (it.func == FUNC_WRITE) begin
      gen_written[it.bone] = 1;
      gen_parent[it.bone] = it.parent;
    end
    req.valid <= 1;
    req.func <= it.func;
    req.bone <= it.bone;
    req.parent <= it.parent;
    req.trans_x <= it.tx;
    req.trans_y <= it.ty;
    req.trans_z <= it.tz;
    req.quat_w <= it.qw;
    req.quat_x <= it.qx;
    req.quat_y <= it.qy;
    req.quat_z <= it.qz;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic item_t mk(logic f, logic [5:0] b, parent_t p, word_t x, word_t y,
                               word_t z, quat_el_t w, quat_el_t qx, quat_el_t qy,
                               quat_el_t qz);
    item_t it;
    it.func = f; it.bone = b; it.parent = p;
    it.tx = x; it.ty = y; it.tz = z;
    it.qw = w; it.qx = qx; it.qy = qy; it.qz = qz;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [5:0] b;
    int sel;
    it = mk(FUNC_WRITE, $urandom_range(63), -1, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
    sel = $urandom_range(99);
    if (sel < 55) begin
      for (int tries = 0; tries < 20; tries++) begin
        b = $urandom_range(63);
        if (chain_ready(b)) begin
          it.func = FUNC_QUERY;
          it.bone = b;
          return it;
        end
      end
    end
    sel = $urandom_range(99);
    if (sel < 40) begin
      it.parent = -1;
    end else if (sel < 50) begin
      it.parent = parent_t'(-int'($urandom_range(2, 64)));
    end else begin
      b = $urandom_range(63);
      if (gen_written[b] && (b != it.bone || $urandom_range(9) == 0)) it.parent = b;
    end
    if ($urandom_range(99) < 60) begin
      it.tx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      it.ty = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      it.tz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    if ($urandom_range(99) < 70) begin
      it.qw = $urandom_range(0, 1) ? 16384 : -16384;
      it.qx = $signed($urandom_range(0, 4096)) - 2048;
      it.qy = $signed($urandom_range(0, 4096)) - 2048;
      it.qz = $signed($urandom_range(0, 4096)) - 2048;
    end
    return it;
  endfunction

  initial begin
    dir_t dir [$];
    dir_t d;
    row_t tr;
    req.valid = 0;
    req.func = 0;
    req.bone = 0;
    req.parent = 0;
    req.trans_x = 0;
    req.trans_y = 0;
    req.trans_z = 0;
    req.quat_w = 0;
    req.quat_x = 0;
    req.quat_y = 0;
    req.quat_z = 0;
    foreach (gen_written[i]) begin
      gen_written[i] = 0;
      gen_parent[i] = 0;
    end

    d = '{default: 0};
    d.it = mk(FUNC_WRITE, 0, -1, 0, 0, 0, 16384, 0, 0, 0);                      dir = {dir, d};
    d.it = mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0); d.typed = 1;             dir = {dir, d};
    d = '{default: 0};
    d.it = mk(FUNC_WRITE, 1, -1, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0, 0);    dir = {dir, d};
    d.it = mk(FUNC_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0); d.typed = 1;
    d.t0 = 32'h7fffffff; d.t1 = 32'h80000000; d.t2 = 1;                       dir = {dir, d};
    d = '{default: 0};
    d.it = mk(FUNC_WRITE, 2, 0, 1, 2, 3, -32768, 0, 0, 0);                     dir = {dir, d};
    d.it = mk(FUNC_QUERY, 2, 0, 0, 0, 0, 0, 0, 0, 0); d.typed = 1;
    d.t0 = 1; d.t1 = 2; d.t2 = 3;                                              dir = {dir, d};
    d = '{default: 0};
    d.it = mk(FUNC_WRITE, 3, 3, 0, 0, 0, 16384, 0, 0, 0);                      dir = {dir, d};
    d.it = mk(FUNC_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0); d.typed = 1; d.err = 1;  dir = {dir, d};
    d = '{default: 0};
    d.it = mk(FUNC_WRITE, 4, -64, -1, -65536, 65536, 0, -32768, 32767, -32768); dir = {dir, d};
    d.it = mk(FUNC_QUERY, 4, 0, 0, 0, 0, 0, 0, 0, 0);                          dir = {dir, d};
    d.it = mk(FUNC_WRITE, 63, -1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32767, 32767, 32767, 32767);                                       dir = {dir, d};
    d.it = mk(FUNC_WRITE, 5, 63, 32'h80000000, 5, -5, 16384, 0, 0, 0);         dir = {dir, d};
    d.it = mk(FUNC_QUERY, 5, 0, 0, 0, 0, 0, 0, 0, 0);                          dir = {dir, d};
    d.it = mk(FUNC_QUERY, 63, 0, 0, 0, 0, 0, 0, 0, 0);                         dir = {dir, d};
    d.it = mk(FUNC_WRITE, 62, 62, 65536, 0, -3, 11585, 11585, 0, 0);           dir = {dir, d};
    d.it = mk(FUNC_QUERY, 62, 0, 0, 0, 0, 0, 0, 0, 0);                         dir = {dir, d};
    d.it = mk(FUNC_WRITE, 6, 2, 0, 65536, 0, 11585, 0, 0, -11585);             dir = {dir, d};
    d.it = mk(FUNC_QUERY, 6, 0, 0, 0, 0, 0, 0, 0, 0);                          dir = {dir, d};

    repeat (4) @(posedge clk);
    rst <= 0;

    foreach (dir[n]) begin
      if (dir[n].it.func == FUNC_QUERY) begin
        typed_flags = {typed_flags, dir[n].typed};
        if (dir[n].typed)
          for (int i = 0; i < 3; i++) begin
            tr.row = 2'(i);
            tr.c0 = (i == 0) ? 65536 : 0;
            tr.c1 = (i == 1) ? 65536 : 0;
            tr.c2 = (i == 2) ? 65536 : 0;
            tr.c3 = (i == 0) ? dir[n].t0 : (i == 1) ? dir[n].t1 : dir[n].t2;
            tr.last = (i == 2);
            tr.err = dir[n].err;
            typed_rows = {typed_rows, tr};
          end
      end
      send(dir[n].it);
    end

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 81 : (phase == 3) ? 13 : 0;
      stall_pct = (phase == 2) ? 81 : (phase == 3) ? 13 : 0;
      if (phase == 0) hold_left = 2500;
      for (int n = 0; n < 40; n++) begin
        item_t it;
        it = random_item();
        if (it.func == FUNC_QUERY) typed_flags = {typed_flags, 1'b0};
        send(it);
      end
    end
    req.valid <= 0;

    while (rows_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("[bone_chain_transform_unit] OK");
    else
      $display("[bone_chain_transform_unit] ERROR");
    $finish;
  end
endmodule
